// ----- hw/rtl/credit_round_robin_dispatcher_macros.svh -----
// Assertion macros shared by the dispatcher RTL.
`ifndef CREDIT_ROUND_ROBIN_DISPATCHER_MACROS_SVH
`define CREDIT_ROUND_ROBIN_DISPATCHER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define CRRD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crrd assertion failed");
// Next-cycle implication.
`define CRRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crrd assertion failed");
`else
`define CRRD_ASSERT_IMP(label, clk, rst, ante, cons)
`define CRRD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/crrd_pkg.sv -----
// Types, constants and helper functions of the round-robin dispatcher.
`timescale 1ns / 1ps
`default_nettype none
package crrd_pkg;

   // Sizes of the worker pool and of the backlog.
   localparam int MAX_WORKERS   = 8;
   localparam int BACKLOG_DEPTH = 16;

   // Field widths.
   localparam int WORKER_W  = 3;
   localparam int NUM_W     = 4;
   localparam int COUNT_W   = 4;
   localparam int LIMIT_W   = 4;
   localparam int LEVEL_W   = 3;
   localparam int MODE_W    = 2;
   localparam int IMP_W     = 3;
   localparam int ACTION_W  = 2;
   localparam int ID_W      = 32;
   localparam int BL_PTR_W  = (BACKLOG_DEPTH > 1) ? $clog2(BACKLOG_DEPTH) : 1;
   localparam int BL_FILL_W = $clog2(BACKLOG_DEPTH + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Configuration reset values.
   localparam logic [NUM_W-1:0]   NUM_WORKERS_RST   = 4'd1;
   localparam logic [LIMIT_W-1:0] BASIC_LIMIT_RST   = 4'd2;
   localparam logic [LIMIT_W-1:0] CRIT_LIMIT_RST    = 4'd4;
   localparam logic [LEVEL_W-1:0] ONGOING_LEVEL_RST = 3'd3;
   localparam logic [LEVEL_W-1:0] DEMAND_LEVEL_RST  = 3'd4;

   typedef enum logic [MODE_W-1:0] {
      MODE_SUBMIT   = 2'd0,
      MODE_COMPLETE = 2'd1,
      MODE_RESET    = 2'd2
   } mode_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_DISPATCH = 2'd0,
      ACT_BACKLOG  = 2'd1,
      ACT_REJECT   = 2'd2,
      ACT_NONE     = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_WORKERS   = 3'd0,
      CSR_BASIC_LIMIT   = 3'd1,
      CSR_CRIT_LIMIT    = 3'd2,
      CSR_ONGOING_LEVEL = 3'd3,
      CSR_DEMAND_LEVEL  = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PASS1,
      ST_PASS2,
      ST_FAIL,
      ST_CMPL,
      ST_NONE
   } seq_state_type;

   typedef struct packed {
      logic [NUM_W-1:0]   num_workers;
      logic [LIMIT_W-1:0] basic_limit;
      logic [LIMIT_W-1:0] crit_limit;
      logic [LEVEL_W-1:0] ongoing_level;
      logic [LEVEL_W-1:0] demand_level;
   } cfg_type;

   // Access to the outstanding-count memory.
   typedef struct packed {
      logic                rd_en;
      logic [WORKER_W-1:0] rd_addr;
      logic                wr_en;
      logic [WORKER_W-1:0] wr_addr;
      logic [COUNT_W-1:0]  wr_data;
   } count_cmd_type;

   // Access to the backlog queue.
   typedef struct packed {
      logic            push;
      logic [ID_W-1:0] push_id;
      logic            rd_en;
      logic            pop;
   } bl_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } bl_status_type;

   // Worker count in use: zero acts as one, large values saturate.
   function automatic logic [NUM_W-1:0] active_workers(input logic [NUM_W-1:0] num);
      logic [NUM_W-1:0] n;
      n = num;
      if (n == '0) begin
         n = NUM_W'(1);
      end
      if (n > NUM_W'(MAX_WORKERS)) begin
         n = NUM_W'(MAX_WORKERS);
      end
      return n;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      return (c == COUNT_MAX) ? c : COUNT_W'(c + 1'b1);
   endfunction

   function automatic logic [COUNT_W-1:0] sat_dec(input logic [COUNT_W-1:0] c);
      return (c == '0) ? c : COUNT_W'(c - 1'b1);
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/crrd_req_if.sv -----
// Request channel into the dispatcher.
`timescale 1ns / 1ps
`default_nettype none
interface crrd_req_if;
   logic                          valid;
   logic                          ready;
   logic [crrd_pkg::MODE_W-1:0]   mode;
   logic [crrd_pkg::IMP_W-1:0]    importance;
   logic [crrd_pkg::WORKER_W-1:0] worker_index;

   modport source (output valid, mode, importance, worker_index, input ready);
   modport sink (input valid, mode, importance, worker_index, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/crrd_rsp_if.sv -----
// Response channel out of the dispatcher.
`timescale 1ns / 1ps
`default_nettype none
interface crrd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [crrd_pkg::ACTION_W-1:0] action;
   logic [crrd_pkg::WORKER_W-1:0] target_worker;
   logic [crrd_pkg::ID_W-1:0]     request_id;

   modport source (output valid, action, target_worker, request_id, input ready);
   modport sink (input valid, action, target_worker, request_id, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/credit_round_robin_dispatcher.sv -----
// Top level of the credit-based round-robin request dispatcher.
//
//   channel   direction  handshake           payload
//   req_chan  in         valid / ready       mode, importance, worker_index
//   rsp_chan  out        valid / ready       action, target_worker, request_id
//   csr_*     in         csr_wr_en (no wait) csr_index, csr_wdata
//
// A submit searches the workers in use, reading one worker's count per cycle from the
// count memory, first against the basic limit, then, for importance above the ongoing
// level, against the critical limit. Completions, resets and ignored requests skip it.
// Reset is synchronous; counts read as zero through per-worker valid bits, so no
// clearing pass follows reset. A stalled response waits in the output register while
// the next request is accepted; that request holds its final step until it drains.
`timescale 1ns / 1ps
`default_nettype none
module credit_round_robin_dispatcher (
   input  logic                              clock,
   input  logic                              reset,
   crrd_req_if.sink                          req_chan,
   crrd_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [crrd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [crrd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   crrd_pkg::cfg_type        cfg_ff;
   crrd_pkg::count_cmd_type  cnt_cmd;
   logic [crrd_pkg::COUNT_W-1:0] cnt_rd;
   crrd_pkg::bl_cmd_type     bl_cmd;
   crrd_pkg::bl_status_type  bl_status;
   logic [crrd_pkg::ID_W-1:0] bl_rd_id;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_workers   <= crrd_pkg::NUM_WORKERS_RST;
         cfg_ff.basic_limit   <= crrd_pkg::BASIC_LIMIT_RST;
         cfg_ff.crit_limit    <= crrd_pkg::CRIT_LIMIT_RST;
         cfg_ff.ongoing_level <= crrd_pkg::ONGOING_LEVEL_RST;
         cfg_ff.demand_level  <= crrd_pkg::DEMAND_LEVEL_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            crrd_pkg::CSR_NUM_WORKERS: begin
               cfg_ff.num_workers <= csr_wdata[crrd_pkg::NUM_W-1:0];
            end
            crrd_pkg::CSR_BASIC_LIMIT: begin
               cfg_ff.basic_limit <= csr_wdata[crrd_pkg::LIMIT_W-1:0];
            end
            crrd_pkg::CSR_CRIT_LIMIT: begin
               cfg_ff.crit_limit <= csr_wdata[crrd_pkg::LIMIT_W-1:0];
            end
            crrd_pkg::CSR_ONGOING_LEVEL: begin
               cfg_ff.ongoing_level <= csr_wdata[crrd_pkg::LEVEL_W-1:0];
            end
            crrd_pkg::CSR_DEMAND_LEVEL: begin
               cfg_ff.demand_level <= csr_wdata[crrd_pkg::LEVEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   crrd_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .cnt_cmd   (cnt_cmd),
      .cnt_rd    (cnt_rd),
      .bl_cmd    (bl_cmd),
      .bl_status (bl_status),
      .bl_rd_id  (bl_rd_id)
   );

   crrd_count u_count (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cnt_cmd),
      .rd_count (cnt_rd)
   );

   crrd_backlog u_backlog (
      .clock  (clock),
      .reset  (reset),
      .cmd    (bl_cmd),
      .status (bl_status),
      .rd_id  (bl_rd_id)
   );
endmodule
`default_nettype wire

// ----- hw/rtl/crrd_ram.sv -----
// Generic one-write one-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module crrd_ram #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 4
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array and read register.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/crrd_count.sv -----
// Outstanding-count memory with per-worker valid bits standing for the zero reset.
`timescale 1ns / 1ps
`default_nettype none
module crrd_count (
   input  logic                           clock,
   input  logic                           reset,
   input  crrd_pkg::count_cmd_type        cmd,
   output logic [crrd_pkg::COUNT_W-1:0]   rd_count
);
   logic [crrd_pkg::MAX_WORKERS-1:0] valid_ff;
   logic                             rd_valid_ff;
   logic [crrd_pkg::COUNT_W-1:0]     ram_q;

   crrd_ram #(
      .DEPTH (crrd_pkg::MAX_WORKERS),
      .WIDTH (crrd_pkg::COUNT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (cmd.wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (ram_q)
   );

   // An entry becomes valid on its first write; reset invalidates all of them.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[cmd.wr_addr] <= 1'b1;
      end
   end

   // Valid bit travels alongside the registered read.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_valid_ff <= valid_ff[cmd.rd_addr];
      end
   end

   assign rd_count = rd_valid_ff ? ram_q : '0;
endmodule
`default_nettype wire

// ----- hw/rtl/crrd_backlog.sv -----
// Backlog FIFO of request ids, held in a synchronous RAM.
`timescale 1ns / 1ps
`default_nettype none
`include "credit_round_robin_dispatcher_macros.svh"
module crrd_backlog (
   input  logic                        clock,
   input  logic                        reset,
   input  crrd_pkg::bl_cmd_type        cmd,
   output crrd_pkg::bl_status_type     status,
   output logic [crrd_pkg::ID_W-1:0]   rd_id
);
   localparam int PTR_W  = crrd_pkg::BL_PTR_W;
   localparam int FILL_W = crrd_pkg::BL_FILL_W;
   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(crrd_pkg::BACKLOG_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(crrd_pkg::BACKLOG_DEPTH);

   logic [PTR_W-1:0]  head_ff;
   logic [PTR_W-1:0]  tail_ff;
   logic [FILL_W-1:0] fill_ff;

   crrd_ram #(
      .DEPTH (crrd_pkg::BACKLOG_DEPTH),
      .WIDTH (crrd_pkg::ID_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (tail_ff),
      .wr_data (cmd.push_id),
      .rd_en   (cmd.rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_id)
   );

   // Head, tail and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (cmd.push) begin
            tail_ff <= (tail_ff == PTR_LAST) ? '0 : PTR_W'(tail_ff + 1'b1);
         end
         if (cmd.pop) begin
            head_ff <= (head_ff == PTR_LAST) ? '0 : PTR_W'(head_ff + 1'b1);
         end
         if (cmd.push && !cmd.pop) begin
            fill_ff <= FILL_W'(fill_ff + 1'b1);
         end else if (cmd.pop && !cmd.push) begin
            fill_ff <= FILL_W'(fill_ff - 1'b1);
         end
      end
   end

   assign status.empty = (fill_ff == '0);
   assign status.full  = (fill_ff == FILL_FULL);

   `CRRD_ASSERT_IMP(a_no_push_when_full, clock, reset, cmd.push, !status.full)
   `CRRD_ASSERT_IMP(a_no_pop_when_empty, clock, reset, cmd.pop, !status.empty)
   `CRRD_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_FULL)
   `CRRD_ASSERT_IMP(a_empty_ptrs_meet, clock, reset, status.empty, head_ff == tail_ff)
endmodule
`default_nettype wire

// ----- hw/rtl/crrd_seq.sv -----
// Request sequencer: round-robin search, backlog handling and response register.
`timescale 1ns / 1ps
`default_nettype none
`include "credit_round_robin_dispatcher_macros.svh"
module crrd_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  crrd_pkg::cfg_type             cfg,
   crrd_req_if.sink                      req,
   crrd_rsp_if.source                    rsp,
   output crrd_pkg::count_cmd_type       cnt_cmd,
   input  logic [crrd_pkg::COUNT_W-1:0]  cnt_rd,
   output crrd_pkg::bl_cmd_type          bl_cmd,
   input  crrd_pkg::bl_status_type       bl_status,
   input  logic [crrd_pkg::ID_W-1:0]     bl_rd_id
);
   localparam int NW  = crrd_pkg::NUM_W;
   localparam int WW  = crrd_pkg::WORKER_W;
   localparam int IDW = crrd_pkg::ID_W;
   localparam logic [IDW-1:0] ID_ONE = IDW'(1);
   localparam logic [NW-1:0]  LEFT_LAST = NW'(1);

   crrd_pkg::seq_state_type state_ff, state_in;
   logic [WW-1:0]                  rr_ff, rr_in;
   logic [NW-1:0]                  left_ff, left_in;
   logic [IDW-1:0]                 next_id_ff, next_id_in;
   logic [IDW-1:0]                 id_ff;
   logic [crrd_pkg::IMP_W-1:0]     imp_ff;
   logic [WW-1:0]                  widx_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   crrd_pkg::action_type           rsp_action_ff;
   logic [WW-1:0]                  rsp_target_ff;
   logic [IDW-1:0]                 rsp_id_ff;

   logic [NW-1:0]                  n_active;
   logic [NW-1:0]                  rr_plus;
   logic [WW-1:0]                  rr_adv;
   logic                           out_free;
   logic                           req_fire;
   logic                           widx_ok;
   logic [crrd_pkg::COUNT_W-1:0]   cnt_dec;
   logic                           in_search;
   logic                           submit_fire;

   logic                           emit;
   crrd_pkg::action_type           emit_action;
   logic [WW-1:0]                  emit_target;
   logic [IDW-1:0]                 emit_id;

   // Shared helpers for the search and the handshake.
   assign n_active = crrd_pkg::active_workers(cfg.num_workers);
   assign rr_plus  = NW'(rr_ff) + NW'(1);
   assign rr_adv   = (rr_plus >= n_active) ? '0 : rr_plus[WW-1:0];
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == crrd_pkg::ST_IDLE);
   assign req_fire = req.valid && req.ready;
   assign widx_ok  = (NW'(req.worker_index) < n_active);
   assign cnt_dec  = crrd_pkg::sat_dec(cnt_rd);

   // Conditions watched by the assertions.
   assign in_search   = (state_ff == crrd_pkg::ST_PASS1) || (state_ff == crrd_pkg::ST_PASS2);
   assign submit_fire = req_fire && (req.mode == crrd_pkg::MODE_SUBMIT);

   // Next state, memory commands and result.
   always_comb begin
      state_in    = state_ff;
      rr_in       = rr_ff;
      left_in     = left_ff;
      next_id_in  = next_id_ff;
      cnt_cmd     = '0;
      bl_cmd      = '0;
      emit        = 1'b0;
      emit_action = crrd_pkg::ACT_NONE;
      emit_target = '0;
      emit_id     = '0;

      case (state_ff)
         crrd_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req.mode)
                  crrd_pkg::MODE_SUBMIT: begin
                     next_id_in      = next_id_ff + ID_ONE;
                     rr_in           = rr_adv;
                     left_in         = n_active;
                     cnt_cmd.rd_en   = 1'b1;
                     cnt_cmd.rd_addr = rr_adv;
                     state_in        = crrd_pkg::ST_PASS1;
                  end
                  crrd_pkg::MODE_COMPLETE: begin
                     if (widx_ok) begin
                        cnt_cmd.rd_en   = 1'b1;
                        cnt_cmd.rd_addr = req.worker_index;
                        bl_cmd.rd_en    = 1'b1;
                        state_in        = crrd_pkg::ST_CMPL;
                     end else begin
                        state_in = crrd_pkg::ST_NONE;
                     end
                  end
                  crrd_pkg::MODE_RESET: begin
                     if (widx_ok) begin
                        cnt_cmd.wr_en   = 1'b1;
                        cnt_cmd.wr_addr = req.worker_index;
                        cnt_cmd.wr_data = '0;
                     end
                     state_in = crrd_pkg::ST_NONE;
                  end
                  default: begin
                     state_in = crrd_pkg::ST_NONE;
                  end
               endcase
            end
         end

         // First pass: one worker per cycle against the basic limit.
         crrd_pkg::ST_PASS1: begin
            if (cnt_rd < cfg.basic_limit) begin
               if (out_free) begin
                  cnt_cmd.wr_en   = 1'b1;
                  cnt_cmd.wr_addr = rr_ff;
                  cnt_cmd.wr_data = crrd_pkg::sat_inc(cnt_rd);
                  emit            = 1'b1;
                  emit_action     = crrd_pkg::ACT_DISPATCH;
                  emit_target     = rr_ff;
                  emit_id         = id_ff;
                  state_in        = crrd_pkg::ST_IDLE;
               end
            end else if (left_ff == LEFT_LAST) begin
               if (imp_ff > cfg.ongoing_level) begin
                  left_in  = n_active;
                  state_in = crrd_pkg::ST_PASS2;
               end else begin
                  state_in = crrd_pkg::ST_FAIL;
               end
            end else begin
               left_in         = NW'(left_ff - 1'b1);
               rr_in           = rr_adv;
               cnt_cmd.rd_en   = 1'b1;
               cnt_cmd.rd_addr = rr_adv;
            end
         end

         // Second pass: starts at the last worker seen, critical limit.
         crrd_pkg::ST_PASS2: begin
            if (cnt_rd < cfg.crit_limit) begin
               if (out_free) begin
                  cnt_cmd.wr_en   = 1'b1;
                  cnt_cmd.wr_addr = rr_ff;
                  cnt_cmd.wr_data = crrd_pkg::sat_inc(cnt_rd);
                  emit            = 1'b1;
                  emit_action     = crrd_pkg::ACT_DISPATCH;
                  emit_target     = rr_ff;
                  emit_id         = id_ff;
                  state_in        = crrd_pkg::ST_IDLE;
               end
            end else if (left_ff == LEFT_LAST) begin
               state_in = crrd_pkg::ST_FAIL;
            end else begin
               left_in         = NW'(left_ff - 1'b1);
               rr_in           = rr_adv;
               cnt_cmd.rd_en   = 1'b1;
               cnt_cmd.rd_addr = rr_adv;
            end
         end

         // No worker had room: backlog an important request, else reject.
         crrd_pkg::ST_FAIL: begin
            if (out_free) begin
               emit    = 1'b1;
               emit_id = id_ff;
               if ((imp_ff >= cfg.demand_level) && !bl_status.full) begin
                  bl_cmd.push    = 1'b1;
                  bl_cmd.push_id = id_ff;
                  emit_action    = crrd_pkg::ACT_BACKLOG;
               end else begin
                  emit_action = crrd_pkg::ACT_REJECT;
               end
               state_in = crrd_pkg::ST_IDLE;
            end
         end

         // Completion frees a credit and hands the backlog head, if any, to that worker.
         crrd_pkg::ST_CMPL: begin
            if (out_free) begin
               emit            = 1'b1;
               cnt_cmd.wr_en   = 1'b1;
               cnt_cmd.wr_addr = widx_ff;
               if (!bl_status.empty) begin
                  bl_cmd.pop      = 1'b1;
                  cnt_cmd.wr_data = crrd_pkg::sat_inc(cnt_dec);
                  emit_action     = crrd_pkg::ACT_DISPATCH;
                  emit_target     = widx_ff;
                  emit_id         = bl_rd_id;
               end else begin
                  cnt_cmd.wr_data = cnt_dec;
               end
               state_in = crrd_pkg::ST_IDLE;
            end
         end

         crrd_pkg::ST_NONE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = crrd_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = crrd_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crrd_pkg::ST_IDLE;
         rr_ff        <= '0;
         left_ff      <= '0;
         next_id_ff   <= ID_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rr_ff        <= rr_in;
         left_ff      <= left_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request fields held for the duration of the work.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         id_ff   <= next_id_ff;
         imp_ff  <= req.importance;
         widx_ff <= req.worker_index;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_action_ff <= emit_action;
         rsp_target_ff <= emit_target;
         rsp_id_ff     <= emit_id;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.action        = rsp_action_ff;
   assign rsp.target_worker = rsp_target_ff;
   assign rsp.request_id    = rsp_id_ff;

   `CRRD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, state_ff != crrd_pkg::ST_IDLE)
   `CRRD_ASSERT_IMP(a_left_nonzero, clock, reset, in_search, left_ff != '0)
   `CRRD_ASSERT_NEXT(a_id_advance, clock, reset, submit_fire, next_id_ff == $past(next_id_ff) + ID_ONE)
   `CRRD_ASSERT_IMP(a_emit_only_when_free, clock, reset, emit, out_free)
endmodule
`default_nettype wire
